[sv/nti_pkg.sv]
// Shared constants and types for the noise table interpolator.
`default_nettype none

package nti_pkg;

    // Default parameter values.
    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_FRAC_BITS   = 16;

    // Fixed field widths.
    localparam int DATA_W     = 32;
    localparam int COORD_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Divider partial remainder width: one bit above the 32-bit divisor.
    localparam int REM_W = 33;

    // Look angle indexing: 16.3 degrees at entry 0, ten entries per degree.
    localparam logic [COORD_W-1:0] LOOK_BASE = 32'd1630;
    localparam logic [COORD_W-1:0] LOOK_STEP = 32'd10;

    // Index modes; the unused code behaves as pixel mode.
    localparam logic [1:0] MODE_PIXEL = 2'd0;
    localparam logic [1:0] MODE_SLANT = 2'd1;
    localparam logic [1:0] MODE_LOOK  = 2'd2;

    // Item commands.
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLANT_START  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLANT_SPAN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH = 3'd4;

    // Configuration reset values.
    localparam logic [1:0]  RST_INDEX_MODE   = MODE_PIXEL;
    localparam logic [15:0] RST_SAMPLES      = 16'd8192;
    localparam logic [31:0] RST_SLANT_START  = 32'd0;
    localparam logic [31:0] RST_SLANT_SPAN   = 32'd1;
    localparam logic [8:0]  RST_TABLE_LENGTH = 9'd256;

    // Item information that rides alongside the divider.
    typedef struct packed {
        logic        cmd;
        logic [7:0]  entry_index;
        logic [31:0] entry_value;
        logic        below;
        logic        clamp;
    } side_t;

endpackage

`default_nettype wire

[sv/nti_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module nti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; a read returns the old word.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[sv/nti_div_pipe.sv]
// Pipelined restoring divider that produces one quotient bit per stage.
`default_nettype none

module nti_div_pipe import nti_pkg::*; #(
    parameter int QUO_W  = 24,
    parameter int LOW_W  = 8,
    parameter int SIDE_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [REM_W-1:0]  in_rem,
    input  wire logic [LOW_W-1:0]  in_low,
    input  wire logic [31:0]       in_div,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic      [QUO_W-1:0]  out_quo,
    output logic      [SIDE_W-1:0] out_side
);

    logic              valid_reg [QUO_W];
    logic [REM_W-1:0]  rem_reg   [QUO_W];
    logic [QUO_W-1:0]  low_reg   [QUO_W];
    logic [QUO_W-1:0]  quo_reg   [QUO_W];
    logic [31:0]       div_reg   [QUO_W];
    logic [SIDE_W-1:0] side_reg  [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic              valid_in;
        logic [REM_W-1:0]  rem_in;
        logic [QUO_W-1:0]  low_in;
        logic [QUO_W-1:0]  quo_in;
        logic [31:0]       div_in;
        logic [SIDE_W-1:0] side_in;
        logic [REM_W:0]    trial;
        logic              ge;
        logic [REM_W-1:0]  rem_next;

        // Stage inputs come from the ports or from the previous stage.
        if (k == 0) begin : g_first
            assign valid_in = in_valid;
            assign rem_in   = in_rem;
            assign low_in   = {in_low, {(QUO_W-LOW_W){1'b0}}};
            assign quo_in   = '0;
            assign div_in   = in_div;
            assign side_in  = in_side;
        end else begin : g_next
            assign valid_in = valid_reg[k-1];
            assign rem_in   = rem_reg[k-1];
            assign low_in   = low_reg[k-1];
            assign quo_in   = quo_reg[k-1];
            assign div_in   = div_reg[k-1];
            assign side_in  = side_reg[k-1];
        end

        // Shift in the next dividend bit and try one subtraction.
        assign trial    = {rem_in, low_in[QUO_W-1]};
        assign ge       = trial >= {2'b00, div_in};
        assign rem_next = ge ? REM_W'(trial - {2'b00, div_in}) : trial[REM_W-1:0];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                low_reg[k]  <= {low_in[QUO_W-2:0], 1'b0};
                quo_reg[k]  <= {quo_in[QUO_W-2:0], ge};
                div_reg[k]  <= div_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule

`default_nettype wire

[sv/noise_table_interpolator.sv]
// Top level of the noise table interpolator: index front end, divider, table, blend.
//
// Items enter on the s_ channel (valid/ready). A write item (cmd 0) stores
// entry_value at entry_index; it travels down the pipeline and updates the
// table in order with the lookups around it, and gives no result. A lookup
// item (cmd 1) turns coord into a table index with FRAC_BITS fraction bits
// and returns the linearly interpolated noise value on the m_ channel,
// together with a flag when the index ran off the end of the table.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata;
// the user must write them only while no items are in flight; the block does not enforce it.
// The divider resolves one quotient bit per stage. One item is accepted per
// cycle unless the output stalls. When m_ready is low and a result is waiting,
// the whole pipeline holds and s_ready drops; no item is lost or repeated.
// Reset clears all valid bits and loads the register defaults; the table
// contents are undefined until written.
`default_nettype none

module noise_table_interpolator import nti_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_cmd,
    input  wire logic [7:0]             s_entry_index,
    input  wire logic signed [31:0]     s_entry_value,
    input  wire logic [COORD_W-1:0]     s_coord,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic signed [31:0]          m_noise_value,
    output logic                        m_clamped
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int LEN_W  = $clog2(TABLE_DEPTH + 1);
    localparam int NUM_W  = COORD_W + LEN_W;
    localparam int LD_W   = 32 + IDX_W;
    localparam int QUO_W  = IDX_W + FRAC_BITS;
    localparam int SIDE_W = $bits(side_t) + IDX_W;
    localparam int PROD_W = FRAC_BITS + 34;

    // Configuration registers.
    logic [1:0]  index_mode_reg;
    logic [15:0] samples_reg;
    logic [31:0] slant_start_reg;
    logic [31:0] slant_span_reg;
    logic [8:0]  table_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_mode_reg   <= RST_INDEX_MODE;
            samples_reg      <= RST_SAMPLES;
            slant_start_reg  <= RST_SLANT_START;
            slant_span_reg   <= RST_SLANT_SPAN;
            table_length_reg <= RST_TABLE_LENGTH;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_INDEX_MODE:   index_mode_reg   <= cfg_wdata[1:0];
                CFG_SAMPLES:      samples_reg      <= cfg_wdata[15:0];
                CFG_SLANT_START:  slant_start_reg  <= cfg_wdata;
                CFG_SLANT_SPAN:   slant_span_reg   <= cfg_wdata;
                CFG_TABLE_LENGTH: table_length_reg <= cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline advances unless a result waits at the output.
    logic en;
    assign en      = !(m_valid && !m_ready);
    assign s_ready = en;

    // Effective table length and index of the last entry.
    logic [LEN_W-1:0] len_eff;
    logic [IDX_W-1:0] last_idx;

    always_comb begin
        if (table_length_reg < 9'd2) begin
            len_eff = LEN_W'(2);
        end else if (int'(table_length_reg) > TABLE_DEPTH) begin
            len_eff = LEN_W'(TABLE_DEPTH);
        end else begin
            len_eff = LEN_W'(table_length_reg);
        end
        last_idx = IDX_W'(len_eff - LEN_W'(1));
    end

    // Stage A: index numerator and divisor for the selected mode.
    logic [COORD_W-1:0] mul_a;
    logic [LEN_W-1:0]   mul_b;
    logic [31:0]        div_sel;
    logic               below_sel;

    always_comb begin
        case (index_mode_reg)
            MODE_SLANT: begin
                below_sel = s_coord <= slant_start_reg;
                mul_a     = below_sel ? '0 : s_coord - slant_start_reg;
                mul_b     = len_eff;
                div_sel   = (slant_span_reg == '0) ? 32'd1 : slant_span_reg;
            end
            MODE_LOOK: begin
                below_sel = s_coord <= LOOK_BASE;
                mul_a     = below_sel ? '0 : s_coord - LOOK_BASE;
                mul_b     = LEN_W'(1);
                div_sel   = LOOK_STEP;
            end
            default: begin
                below_sel = 1'b0;
                mul_a     = s_coord;
                mul_b     = len_eff;
                div_sel   = (samples_reg == '0) ? 32'd1 : {16'd0, samples_reg};
            end
        endcase
    end

    logic             a_valid_reg;
    side_t            a_side_reg;
    logic [IDX_W-1:0] a_last_reg;
    logic [NUM_W-1:0] a_num_reg;
    logic [31:0]      a_div_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_side_reg.cmd         <= s_cmd;
            a_side_reg.entry_index <= s_entry_index;
            a_side_reg.entry_value <= s_entry_value;
            a_side_reg.below       <= below_sel;
            a_side_reg.clamp       <= 1'b0;
            a_last_reg             <= last_idx;
            a_num_reg              <= NUM_W'(mul_a) * NUM_W'(mul_b);
            a_div_reg              <= div_sel;
        end
    end

    // Stage B: the numerator bound where the index reaches the last entry.
    logic             b_valid_reg;
    side_t            b_side_reg;
    logic [IDX_W-1:0] b_last_reg;
    logic [NUM_W-1:0] b_num_reg;
    logic [31:0]      b_div_reg;
    logic [LD_W-1:0]  b_bound_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_side_reg  <= a_side_reg;
            b_last_reg  <= a_last_reg;
            b_num_reg   <= a_num_reg;
            b_div_reg   <= a_div_reg;
            b_bound_reg <= LD_W'(a_div_reg) * LD_W'(a_last_reg);
        end
    end

    // Stage C: clamp decision and divider set-up.
    logic             c_valid_reg;
    side_t            c_side_reg;
    logic [IDX_W-1:0] c_last_reg;
    logic [REM_W-1:0] c_rem_reg;
    logic [IDX_W-1:0] c_low_reg;
    logic [31:0]      c_div_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_side_reg.cmd         <= b_side_reg.cmd;
            c_side_reg.entry_index <= b_side_reg.entry_index;
            c_side_reg.entry_value <= b_side_reg.entry_value;
            c_side_reg.below       <= b_side_reg.below;
            c_side_reg.clamp       <= b_num_reg >= NUM_W'(b_bound_reg);
            c_last_reg             <= b_last_reg;
            c_rem_reg              <= REM_W'(b_num_reg >> IDX_W);
            c_low_reg              <= b_num_reg[IDX_W-1:0];
            c_div_reg              <= b_div_reg;
        end
    end

    // Divider: index with fraction bits, exact whenever the item is not clamped.
    logic              dv_valid;
    logic [QUO_W-1:0]  dv_quo;
    logic [SIDE_W-1:0] dv_side_bits;

    nti_div_pipe #(
        .QUO_W  (QUO_W),
        .LOW_W  (IDX_W),
        .SIDE_W (SIDE_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (c_valid_reg),
        .in_rem    (c_rem_reg),
        .in_low    (c_low_reg),
        .in_div    (c_div_reg),
        .in_side   ({c_side_reg, c_last_reg}),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side_bits)
    );

    side_t            dv_side;
    logic [IDX_W-1:0] dv_last;
    logic [IDX_W-1:0] dv_q;
    logic [IDX_W-1:0] addr_a;
    logic [IDX_W-1:0] addr_b;
    logic             dv_below;
    logic             tbl_we;

    // Table addresses: the single entry used at either end, or the two neighbors.
    always_comb begin
        {dv_side, dv_last} = dv_side_bits;
        dv_q     = dv_quo[QUO_W-1:FRAC_BITS];
        dv_below = dv_side.below || (!dv_side.clamp && dv_quo == '0);
        if (dv_below) begin
            addr_a = '0;
        end else if (dv_side.clamp) begin
            addr_a = dv_last;
        end else begin
            addr_a = dv_q;
        end
        addr_b = dv_q + IDX_W'(1);
        tbl_we = en && dv_valid && dv_side.cmd == CMD_WRITE
                 && int'(dv_side.entry_index) < TABLE_DEPTH;
    end

    // Stage D: table read. Writes land here, in order with the lookups.
    logic [31:0] rd_a;
    logic [31:0] rd_b;

    nti_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram_a (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (IDX_W'(dv_side.entry_index)),
        .wdata (dv_side.entry_value),
        .re    (en),
        .raddr (addr_a),
        .rdata (rd_a)
    );

    nti_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram_b (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (IDX_W'(dv_side.entry_index)),
        .wdata (dv_side.entry_value),
        .re    (en),
        .raddr (addr_b),
        .rdata (rd_b)
    );

    logic                 d_valid_reg;
    logic [FRAC_BITS-1:0] d_frac_reg;
    logic                 d_hold_reg;
    logic                 d_clamp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (en) begin
            d_valid_reg <= dv_valid && dv_side.cmd == CMD_LOOKUP;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_frac_reg  <= dv_quo[FRAC_BITS-1:0];
            d_hold_reg  <= dv_below || dv_side.clamp;
            d_clamp_reg <= dv_side.clamp && !dv_below;
        end
    end

    // Stage E: difference of the neighboring entries.
    logic                 e_valid_reg;
    logic [FRAC_BITS-1:0] e_frac_reg;
    logic                 e_hold_reg;
    logic                 e_clamp_reg;
    logic [31:0]          e_a_reg;
    logic signed [32:0]   e_diff_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (en) begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_frac_reg  <= d_frac_reg;
            e_hold_reg  <= d_hold_reg;
            e_clamp_reg <= d_clamp_reg;
            e_a_reg     <= rd_a;
            e_diff_reg  <= signed'({rd_b[31], rd_b}) - signed'({rd_a[31], rd_a});
        end
    end

    // Stage F: fraction times difference.
    logic signed [FRAC_BITS:0] e_frac_s;
    assign e_frac_s = signed'({1'b0, e_frac_reg});

    logic                     f_valid_reg;
    logic                     f_hold_reg;
    logic                     f_clamp_reg;
    logic [31:0]              f_a_reg;
    logic signed [PROD_W-1:0] f_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (en) begin
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_hold_reg  <= e_hold_reg;
            f_clamp_reg <= e_clamp_reg;
            f_a_reg     <= e_a_reg;
            f_prod_reg  <= PROD_W'(e_frac_s) * PROD_W'(e_diff_reg);
        end
    end

    // Stage G: scale the product down, rounding toward zero, and add the base.
    logic signed [PROD_W-1:0] prod_adj;
    logic signed [PROD_W-1:0] prod_shift;
    logic [31:0]              blend;

    always_comb begin
        prod_adj = f_prod_reg;
        if (f_prod_reg[PROD_W-1]) begin
            prod_adj = f_prod_reg + PROD_W'((64'd1 << FRAC_BITS) - 64'd1);
        end
        prod_shift = prod_adj >>> FRAC_BITS;
        blend      = f_hold_reg ? f_a_reg : f_a_reg + prod_shift[31:0];
    end

    logic        g_valid_reg;
    logic [31:0] g_value_reg;
    logic        g_clamp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_valid_reg <= 1'b0;
        end else if (en) begin
            g_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g_value_reg <= blend;
            g_clamp_reg <= f_clamp_reg;
        end
    end

    assign m_valid       = g_valid_reg;
    assign m_noise_value = signed'(g_value_reg);
    assign m_clamped     = g_clamp_reg;

endmodule

`default_nettype wire
